// ===== design/lru_keyed_lookup_cache_assert.svh =====
// Assertion macros shared by the checker.
`ifndef LRU_KEYED_LOOKUP_CACHE_ASSERT_SVH
`define LRU_KEYED_LOOKUP_CACHE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define LKC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LKC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lkc_pkg.sv =====
package lkc_pkg;

    localparam int ENTRIES_DEF = 256;

    // stream widths
    localparam int S_TDATA_W = 192;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 1;

    localparam int PID_W  = 32;
    localparam int ADDR_W = 64;
    localparam int PAY_W  = 32;
    localparam int TIME_W = 64;
    localparam int SLOT_W = 8;

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_PROBE  = 2'd1,
        ACT_STORE  = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    // one cache line as held in the entry memory
    typedef struct packed {
        logic [PID_W-1:0]  pid;
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] stamp;
        logic [PAY_W-1:0]  payload;
    } t_entry;

    typedef struct packed {
        logic load;    // capture the input transfer, reset scan state
        logic scan;    // step the entry scan
        logic commit;  // write back and hand result to output register
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_status;

endpackage

// ===== design/lkc_ctrl.sv =====
module lkc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output lkc_pkg::t_cmd     o_cmd,
    input  lkc_pkg::t_status  i_status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_ready, n_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid && r_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_done) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                // hold here until the output register can take the result
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_ready = (n_state == ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_s_tready = r_ready;

endmodule

// ===== design/lkc_dpath.sv =====
module lkc_dpath #(
    parameter int ENTRIES = lkc_pkg::ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lkc_pkg::t_cmd                   i_cmd,
    output lkc_pkg::t_status                o_status,
    input  logic [lkc_pkg::S_TDATA_W-1:0]   i_s_tdata,
    input  logic [lkc_pkg::S_TUSER_W-1:0]   i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [lkc_pkg::M_TDATA_W-1:0]   o_m_tdata,
    output logic [lkc_pkg::M_TUSER_W-1:0]   o_m_tuser
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

    // captured item
    lkc_pkg::t_action               r_action;
    logic [lkc_pkg::PID_W-1:0]      r_pid;
    logic [lkc_pkg::ADDR_W-1:0]     r_addr;
    logic [lkc_pkg::PAY_W-1:0]      r_payload;
    logic [lkc_pkg::TIME_W-1:0]     r_now;
    logic                           r_skip;

    // scan state
    logic [CW-1:0]                  r_fill;
    logic [CW-1:0]                  r_idx;
    logic                           r_cmp_vld;
    logic [AW-1:0]                  r_cmp_idx;
    logic                           r_found;
    logic [AW-1:0]                  r_where;
    logic [lkc_pkg::PAY_W-1:0]      r_hit_payload;
    logic [lkc_pkg::TIME_W-1:0]     r_oldest;
    logic [AW-1:0]                  r_cand;

    // entry memory, one port, registered read
    lkc_pkg::t_entry                r_mem [ENTRIES];
    lkc_pkg::t_entry                r_q;

    // output register
    logic                           r_m_valid;
    logic                           r_out_hit;
    logic [lkc_pkg::PAY_W-1:0]      r_out_payload;
    logic [lkc_pkg::SLOT_W-1:0]     r_out_slot;

    logic                           issue;
    logic                           cmp_en;
    logic                           match;
    logic                           full;
    logic [AW-1:0]                  new_slot;
    logic                           res_hit;
    logic [lkc_pkg::PAY_W-1:0]      res_payload;
    logic [AW-1:0]                  res_slot;
    logic                           res_we;
    logic [lkc_pkg::PAY_W-1:0]      res_wpay;
    logic                           fill_inc;
    lkc_pkg::t_entry                wr_entry;
    lkc_pkg::t_action               in_action;
    logic [lkc_pkg::ADDR_W-1:0]     in_addr;

    assign in_action = lkc_pkg::t_action'(i_s_tuser);
    assign in_addr   = i_s_tdata[95:32];

    // valid entries always form the prefix [0, r_fill)
    assign issue  = i_cmd.scan && !r_skip && !r_found && (r_idx != r_fill);
    assign cmp_en = r_cmp_vld && !r_found;
    assign match  = (r_q.pid == r_pid) && (r_q.addr == r_addr);

    assign o_status.scan_done = r_skip || r_found || ((r_idx == r_fill) && !r_cmp_vld);
    assign o_status.out_free  = !r_m_valid || i_m_tready;

    assign full     = (r_fill == FULL_CNT);
    assign new_slot = full ? r_cand : r_fill[AW-1:0];

    always_comb begin
        res_hit     = 1'b0;
        res_payload = '0;
        res_slot    = '0;
        res_we      = 1'b0;
        res_wpay    = r_payload;
        fill_inc    = 1'b0;
        case (r_action)
            lkc_pkg::ACT_LOOKUP: begin
                res_hit     = r_found;
                res_payload = r_found ? r_hit_payload : '0;
                res_slot    = r_found ? r_where : '0;
                res_we      = r_found;
                res_wpay    = r_hit_payload;
            end
            lkc_pkg::ACT_PROBE: begin
                res_hit  = r_found;
                res_slot = r_found ? r_where : '0;
            end
            lkc_pkg::ACT_STORE: begin
                res_hit  = r_found;
                res_slot = r_found ? r_where : new_slot;
                res_we   = 1'b1;
                fill_inc = !r_found && !full;
            end
            default: begin
                res_hit = 1'b0;
            end
        endcase
    end

    assign wr_entry.pid     = r_pid;
    assign wr_entry.addr    = r_addr;
    assign wr_entry.stamp   = r_now;
    assign wr_entry.payload = res_wpay;

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && res_we) begin
            r_mem[res_slot] <= wr_entry;
        end else if (issue) begin
            r_q <= r_mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx     <= '0;
                r_cmp_vld <= 1'b0;
                r_found   <= 1'b0;
            end else if (i_cmd.scan) begin
                r_cmp_vld <= issue;
                if (issue) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (cmp_en && match) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.commit && fill_inc) begin
                r_fill <= r_fill + 1'b1;
            end
            if (i_cmd.commit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action  <= in_action;
            r_pid     <= i_s_tdata[31:0];
            r_addr    <= in_addr;
            r_payload <= i_s_tdata[127:96];
            r_now     <= i_s_tdata[191:128];
            // zero-address lookups/probes and the unused code never match
            r_skip    <= (in_action == lkc_pkg::ACT_NOP) ||
                         ((in_action != lkc_pkg::ACT_STORE) && (in_addr == '0));
            r_oldest  <= '1;
            r_cand    <= '0;
        end else if (i_cmd.scan) begin
            if (cmp_en) begin
                if (match) begin
                    r_where       <= r_cmp_idx;
                    r_hit_payload <= r_q.payload;
                end else if (r_q.stamp < r_oldest) begin
                    r_oldest <= r_q.stamp;
                    r_cand   <= r_cmp_idx;
                end
            end
        end
        if (issue) begin
            r_cmp_idx <= r_idx[AW-1:0];
        end
        if (i_cmd.commit) begin
            r_out_hit     <= res_hit;
            r_out_payload <= res_payload;
            r_out_slot    <= lkc_pkg::SLOT_W'(res_slot);
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {r_out_slot, r_out_payload};
    assign o_m_tuser  = r_out_hit;

endmodule

// ===== design/lru_keyed_lookup_cache.sv =====
// Fully associative lookup cache keyed by (process id, address), one payload
// word and a last-access time per line, least-recently-used replacement by
// timestamp. Actions on tuser: lookup (returns payload, refreshes time;
// address zero always misses), probe (hit/slot only, no time change), store
// (update a matching line, else fill the next free line, else evict the
// lowest-index line with the oldest time). One result transfer per input
// transfer. Lines live in a single-port memory; every action except an
// address zero lookup/probe and the unused code walks the valid lines from
// index 0 one per cycle, stopping at the first key match. Items are taken
// one at a time: the next input is accepted only once the sequencer is
// back in idle after committing the previous result.
// Valid lines are always a prefix tracked by a fill count, so no clearing
// pass follows reset.
// A finished result sits in an output register, so the next input is taken
// while it waits for tready.
module lru_keyed_lookup_cache #(
    parameter int ENTRIES = lkc_pkg::ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave side
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] process_id, [95:32] address, [127:96] payload_in,
    // [191:128] now_time
    input  logic [lkc_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] action
    input  logic [lkc_pkg::S_TUSER_W-1:0]   s_tuser,
    // master side
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] payload_out, [39:32] slot
    output logic [lkc_pkg::M_TDATA_W-1:0]   m_tdata,
    // [0] hit
    output logic [lkc_pkg::M_TUSER_W-1:0]   m_tuser
);

    lkc_pkg::t_cmd    cmd;
    lkc_pkg::t_status status;

    // sequencer: idle -> scan -> commit
    lkc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    // entry memory, scan compare/oldest tracking, output register
    lkc_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

endmodule

// ===== design/lkc_checker.sv =====
`include "lru_keyed_lookup_cache_assert.svh"

module lkc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            i_s_tready,
    input logic                            i_m_tvalid,
    input logic                            i_m_tready,
    input logic [lkc_pkg::M_TDATA_W-1:0]   i_m_tdata,
    input logic [lkc_pkg::M_TUSER_W-1:0]   i_m_tuser
);

    // stalled result holds
    `LKC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser), "result changed while stalled")

    // one item at a time: ready drops right after a transfer
    `LKC_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_s_tvalid && i_s_tready, !i_s_tready, "input taken while busy")

    // a miss never carries payload
    `LKC_ASSERT_NOW(a_miss_no_payload, i_clk, i_rst_n, i_m_tvalid && !i_m_tuser[0], i_m_tdata[31:0] == '0, "payload on miss")

    // no result can appear the cycle right after an input transfer
    `LKC_ASSERT_NEXT(a_min_latency, i_clk, i_rst_n, i_s_tvalid && i_s_tready, !$rose(i_m_tvalid), "result too early")

endmodule

bind lru_keyed_lookup_cache lkc_checker u_lkc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_tvalid),
    .i_s_tready (s_tready),
    .i_m_tvalid (m_tvalid),
    .i_m_tready (m_tready),
    .i_m_tdata  (m_tdata),
    .i_m_tuser  (m_tuser)
);

// ===== dv/lru_keyed_lookup_cache_tb.sv =====
`timescale 1ns / 1ps

module lru_keyed_lookup_cache_tb;

    localparam int LINES        = lkc_pkg::ENTRIES_DEF;
    localparam int KEY_POOL     = 320;        // more keys than lines, so stores must evict
    localparam int PID_POOL     = 6;
    localparam int HOLD_CYCLES  = 2500;       // long output back-pressure stretch
    localparam int DRAIN_CYCLES = 300;        // a full scan plus write-back, with margin
    localparam int LIMIT_NS     = 15_000_000;

    typedef struct packed {
        lkc_pkg::t_action           act;
        logic [lkc_pkg::PID_W-1:0]  pid;
        logic [lkc_pkg::ADDR_W-1:0] addr;
        logic [lkc_pkg::PAY_W-1:0]  payload;
        logic [lkc_pkg::TIME_W-1:0] stamp;
    } t_cache_req;

    typedef struct packed {
        logic                       hit;
        logic [lkc_pkg::PAY_W-1:0]  payload;
        logic [lkc_pkg::SLOT_W-1:0] slot;
    } t_cache_rsp;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    // [31:0] pid, [95:32] addr, [127:96] payload, [191:128] time
    logic [lkc_pkg::S_TDATA_W-1:0] s_tdata;
    logic [lkc_pkg::S_TUSER_W-1:0] s_tuser;    // [1:0] action
    logic                          m_tvalid;
    logic                          m_tready;
    logic [lkc_pkg::M_TDATA_W-1:0] m_tdata;    // [31:0] payload_out, [39:32] slot
    logic [lkc_pkg::M_TUSER_W-1:0] m_tuser;    // [0] hit

    lru_keyed_lookup_cache uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the cache lines
    logic                       line_valid   [LINES];
    logic [lkc_pkg::PID_W-1:0]  line_pid     [LINES];
    logic [lkc_pkg::ADDR_W-1:0] line_addr    [LINES];
    logic [lkc_pkg::TIME_W-1:0] line_stamp   [LINES];
    logic [lkc_pkg::PAY_W-1:0]  line_payload [LINES];

    t_cache_req pending_reqs[$];      // items waiting to be offered
    t_cache_rsp expected_rsps[$];     // predicted results, oldest first

    int         sender_idle_pct;
    int         rx_stall_pct;
    int         hold_req;
    int         hold_ack;
    int         hold_left;
    int         error_count;
    logic       in_accepted;          // last rising edge completed an input transfer
    t_cache_req next_req;
    t_cache_req taken_req;
    t_cache_rsp head_rsp;

    // Key pool and time source for the random part
    logic [lkc_pkg::PID_W-1:0]  pid_pool  [PID_POOL];
    logic [lkc_pkg::ADDR_W-1:0] addr_pool [KEY_POOL];
    logic [lkc_pkg::TIME_W-1:0] tick;
    bit                         freeze_time;
    int                         fill_cursor;
    int                         recent_keys[$];

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic bit holds_key(int i, t_cache_req req);
        return line_valid[i] && line_pid[i] == req.pid && line_addr[i] == req.addr;
    endfunction

    // Apply one access to the shadow lines and return its result.
    function automatic t_cache_rsp predict_cache_access(t_cache_req req);
        t_cache_rsp                 rsp;
        int                         victim;
        logic [lkc_pkg::TIME_W-1:0] oldest;
        int                         i;
        rsp    = '0;
        victim = 0;
        oldest = '1;
        case (req.act)
            lkc_pkg::ACT_LOOKUP, lkc_pkg::ACT_PROBE: begin
                // address zero never hits
                if (req.addr != '0) begin
                    for (i = 0; i < LINES; i++) begin
                        if (holds_key(i, req)) begin
                            rsp.hit  = 1'b1;
                            rsp.slot = lkc_pkg::SLOT_W'(i);
                            if (req.act == lkc_pkg::ACT_LOOKUP) begin
                                rsp.payload   = line_payload[i];
                                line_stamp[i] = req.stamp;
                            end
                            return rsp;
                        end
                    end
                end
            end
            lkc_pkg::ACT_STORE: begin
                // match first, then the first free line ends the search,
                // else the lowest index with a strictly older time wins
                for (i = 0; i < LINES; i++) begin
                    if (holds_key(i, req)) begin
                        line_stamp[i]   = req.stamp;
                        line_payload[i] = req.payload;
                        rsp.hit  = 1'b1;
                        rsp.slot = lkc_pkg::SLOT_W'(i);
                        return rsp;
                    end
                    if (!line_valid[i]) begin
                        victim = i;
                        break;
                    end
                    if (line_stamp[i] < oldest) begin
                        oldest = line_stamp[i];
                        victim = i;
                    end
                end
                line_valid[victim]   = 1'b1;
                line_pid[victim]     = req.pid;
                line_addr[victim]    = req.addr;
                line_stamp[victim]   = req.stamp;
                line_payload[victim] = req.payload;
                rsp.slot = lkc_pkg::SLOT_W'(victim);
            end
            default: ;  // unused code: no operation, all-zero result
        endcase
        return rsp;
    endfunction

    function automatic logic [lkc_pkg::TIME_W-1:0] next_stamp();
        int pick;
        pick = $urandom_range(99);
        if (freeze_time) return tick;     // equal times force eviction ties
        if (pick < 2) return '1;
        if (pick < 4) return '0;
        if (pick < 6) return rand64();
        tick += lkc_pkg::TIME_W'($urandom_range(1, 7));
        return tick;
    endfunction

    // Mostly stores that walk the key pool, plus lookups and probes that
    // favor recently stored keys; some foreign keys and unused codes as noise.
    function automatic t_cache_req random_request();
        t_cache_req req;
        int         k;
        int         pick;
        k    = $urandom_range(KEY_POOL - 1);
        pick = $urandom_range(99);
        req.payload = $urandom;
        req.stamp   = next_stamp();
        if (pick < 48) begin
            req.act = lkc_pkg::ACT_STORE;
            if ($urandom_range(99) < 60) begin
                k = fill_cursor % KEY_POOL;
                fill_cursor++;
            end
            recent_keys.push_back(k);
            if (recent_keys.size() > 8) void'(recent_keys.pop_front());
        end else if (pick < 93) begin
            req.act = (pick < 75) ? lkc_pkg::ACT_LOOKUP : lkc_pkg::ACT_PROBE;
            if (recent_keys.size() > 0 && $urandom_range(1) == 1)
                k = recent_keys[$urandom_range(recent_keys.size() - 1)];
        end else if (pick < 97) begin
            req.act = (pick % 2 == 0) ? lkc_pkg::ACT_LOOKUP : lkc_pkg::ACT_PROBE;
        end else begin
            req.act = lkc_pkg::ACT_NOP;
        end
        req.pid  = pid_pool[k % PID_POOL];
        req.addr = addr_pool[k];
        if (pick >= 93) begin
            req.pid  = $urandom;
            req.addr = rand64();
        end
        return req;
    endfunction

    task automatic queue_req(lkc_pkg::t_action act, logic [lkc_pkg::PID_W-1:0] pid,
                             logic [lkc_pkg::ADDR_W-1:0] addr,
                             logic [lkc_pkg::PAY_W-1:0] payload,
                             logic [lkc_pkg::TIME_W-1:0] stamp);
        t_cache_req req;
        req.act     = act;
        req.pid     = pid;
        req.addr    = addr;
        req.payload = payload;
        req.stamp   = stamp;
        pending_reqs.push_back(req);
    endtask

    task automatic queue_random(int count);
        repeat (count) pending_reqs.push_back(random_request());
    endtask

    task automatic wait_offered();
        while (pending_reqs.size() != 0) @(posedge i_clk);
    endtask

    // Input driver: a new item goes up only once the previous one has transferred.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_tvalid || in_accepted) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    next_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {next_req.stamp, next_req.payload, next_req.addr,
                                 next_req.pid};
                    s_tuser  <= next_req.act;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output ready: random stalls, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Monitor: predict on each input transfer, check each output transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_accepted <= 1'b0;
        end else begin
            in_accepted <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                taken_req.act     = lkc_pkg::t_action'(s_tuser);
                taken_req.pid     = s_tdata[31:0];
                taken_req.addr    = s_tdata[95:32];
                taken_req.payload = s_tdata[127:96];
                taken_req.stamp   = s_tdata[191:128];
                expected_rsps.push_back(predict_cache_access(taken_req));
            end
            if (m_tvalid && m_tready) begin
                if (expected_rsps.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result: expected none, %s %b %h %h",
                             $time, "actual hit/payload/slot",
                             m_tuser[0], m_tdata[31:0], m_tdata[39:32]);
                end else begin
                    head_rsp = expected_rsps.pop_front();
                    if (m_tuser[0] !== head_rsp.hit) begin
                        error_count++;
                        $display("%0t: hit: expected %b actual %b",
                                 $time, head_rsp.hit, m_tuser[0]);
                    end
                    if (m_tdata[31:0] !== head_rsp.payload) begin
                        error_count++;
                        $display("%0t: payload_out: expected %h actual %h",
                                 $time, head_rsp.payload, m_tdata[31:0]);
                    end
                    if (m_tdata[39:32] !== head_rsp.slot) begin
                        error_count++;
                        $display("%0t: slot: expected %h actual %h",
                                 $time, head_rsp.slot, m_tdata[39:32]);
                    end
                end
            end
        end
    end

    initial begin
        int k;
        i_rst_n         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        m_tready        = 1'b0;
        sender_idle_pct = 0;
        rx_stall_pct    = 0;
        hold_req        = 0;
        hold_ack        = 0;
        hold_left       = 0;
        error_count     = 0;
        tick            = 64'd100;
        freeze_time     = 1'b0;
        fill_cursor     = 0;
        for (k = 0; k < LINES; k++) line_valid[k] = 1'b0;

        pid_pool[0] = '0;
        pid_pool[1] = '1;
        for (k = 2; k < PID_POOL; k++) pid_pool[k] = $urandom;
        // random addresses, with some shared between pids, some small, one zero
        for (k = 0; k < KEY_POOL; k++) begin
            if (k > 0 && k % 7 == 0)      addr_pool[k] = addr_pool[k - 1];
            else if (k % 11 == 0)         addr_pool[k] = 64'($urandom_range(255));
            else                          addr_pool[k] = rand64();
        end
        addr_pool[5] = '0;

        // Directed part
        queue_req(lkc_pkg::ACT_LOOKUP, 32'h1, 64'h1, '0, 64'd1);   // empty cache misses
        queue_req(lkc_pkg::ACT_PROBE,  '1, '1, '1, '1);
        queue_req(lkc_pkg::ACT_NOP,    '1, '1, '1, '1);            // unused code
        queue_req(lkc_pkg::ACT_STORE,  '1, '1, '1, '1);            // all-ones key and time
        queue_req(lkc_pkg::ACT_LOOKUP, '1, '1, '0, 64'd2);
        queue_req(lkc_pkg::ACT_PROBE,  '1, '1, '0, 64'd3);         // no time refresh
        queue_req(lkc_pkg::ACT_STORE,  '0, '0, '0, '0);            // address zero stores...
        queue_req(lkc_pkg::ACT_LOOKUP, '0, '0, '0, 64'd4);         // ...but never hits
        queue_req(lkc_pkg::ACT_PROBE,  '0, '0, '0, 64'd5);
        queue_req(lkc_pkg::ACT_STORE,  '1, '1, 32'h1234_5678, 64'd6); // match updates in place
        queue_req(lkc_pkg::ACT_LOOKUP, 32'hFFFF_FFFE, '1, '0, 64'd7); // same address, other pid
        queue_req(lkc_pkg::ACT_LOOKUP, '1, 64'hFFFF_FFFF_FFFF_FFFE, '0, 64'd8);
        queue_req(lkc_pkg::ACT_STORE,  32'h5, 64'h5, 32'hA5A5_5A5A, 64'd9);
        queue_req(lkc_pkg::ACT_STORE,  32'h6, 64'h6, 32'h5A5A_A5A5, 64'd9); // equal times
        queue_req(lkc_pkg::ACT_LOOKUP, '1, '1, '0, 64'd10);
        queue_req(lkc_pkg::ACT_PROBE,  32'h6, 64'h6, '0, 64'd11);
        queue_req(lkc_pkg::ACT_LOOKUP, 32'h5, 64'h5, '0, 64'd12);
        queue_req(lkc_pkg::ACT_NOP,    '0, '0, '0, '0);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Full rate, with one long output hold-off so the block backs up
        queue_random(300);
        while (pending_reqs.size() > 220) @(posedge i_clk);
        hold_req++;
        wait_offered();

        sender_idle_pct = 80;
        rx_stall_pct    = 0;
        queue_random(200);
        wait_offered();

        sender_idle_pct = 0;
        rx_stall_pct    = 80;
        queue_random(200);
        wait_offered();

        // Both sides idling; first half with a frozen time for eviction ties
        sender_idle_pct = 32;
        rx_stall_pct    = 32;
        freeze_time     = 1'b1;
        queue_random(100);
        freeze_time     = 1'b0;
        queue_random(100);
        wait_offered();

        while (s_tvalid || expected_rsps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #LIMIT_NS;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
